@@ design/dfrw_pkg.sv @@
package dfrw_pkg;

    // Field widths fixed by the stream format.
    localparam int SAMPLE_W = 16;
    localparam int WALK_W   = 9;
    localparam int SUM_W    = 48;
    localparam int DELAY_W  = 10;
    localparam int BAND_W   = 9;
    localparam int BURN_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 64;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY_A    = 2'd0,
        REG_DELAY_B    = 2'd1,
        REG_BAND_LIMIT = 2'd2,
        REG_BURN_IN    = 2'd3
    } cfg_reg_t;

    // Register reset values.
    localparam logic [DELAY_W-1:0]       DELAY_A_RST = 10'd50;
    localparam logic [DELAY_W-1:0]       DELAY_B_RST = 10'd0;
    localparam logic signed [BAND_W-1:0] BAND_RST    = 9'sd20;
    localparam logic [BURN_W-1:0]        BURN_RST    = 32'd10000;

    // Up-step thresholds for p = 0.995, 0.5 and 0.005.
    localparam logic [SAMPLE_W-1:0] THR_UP   = 16'd65208;
    localparam logic [SAMPLE_W-1:0] THR_HALF = 16'd32768;
    localparam logic [SAMPLE_W-1:0] THR_DOWN = 16'd328;

    // Saturation limits of the running sum.
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Pair of feedback delays.
    typedef struct packed {
        logic [DELAY_W-1:0] a;
        logic [DELAY_W-1:0] b;
    } dfrw_dly_t;

endpackage

@@ design/delayed_feedback_random_walk_top.sv @@
// Channel  | Signals                                   | Content
// ---------+-------------------------------------------+---------------------------------
// s_axis   | s_tvalid, s_tready, s_tdata[15:0]         | rand_sample
// m_axis   | m_tvalid, m_tready, m_tdata[63:0], m_tuser | walk_value, window_sum; in_window
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | delay_a, delay_b, band_limit, burn_in
//
// One request per clock is taken into the input register while m_axis does not stall;
// its result is loaded into the m_axis output registers after one pass of compare, add and saturate.
// The delayed history values are prefetched from the history memory ahead
// of their use, so the two registered read ports never limit the rate.
// Reset is asynchronous and active low; no clearing pass is needed, as a fill
// count marks which history entries hold written values.
// A stall on m_axis holds the result and backs up into s_tready after one
// more request.
module delayed_feedback_random_walk_top
    import dfrw_pkg::*;
#(
    parameter int SPAN      = 500,
    parameter int MAX_DELAY = 1024
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // [15:0] rand_sample
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // [8:0] walk_value, [56:9] window_sum
    output logic                   m_tuser,   // [0] in_window
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int BOUND = (SPAN / 2 > 255) ? 255 : SPAN / 2;
    localparam logic signed [WALK_W:0] BOUND_P = (WALK_W+1)'(BOUND);
    localparam logic signed [WALK_W:0] BOUND_N = -BOUND_P;

    logic                     cfg_fire;
    logic [DELAY_W-1:0]       delay_a_reg, delay_a_next;
    logic [DELAY_W-1:0]       delay_b_reg, delay_b_next;
    logic signed [BAND_W-1:0] band_limit_reg, band_limit_next;
    logic [BURN_W-1:0]        burn_in_reg, burn_in_next;

    logic                     in_valid_reg;
    logic [SAMPLE_W-1:0]      sample_reg;
    logic                     out_valid_reg;
    logic                     win_reg;
    logic                     fire;
    logic                     stepped_reg;

    logic signed [WALK_W-1:0] latest_reg, latest_next;
    logic [BURN_W-1:0]        step_index_reg, step_index_next, step_inc;
    logic signed [SUM_W-1:0]  running_sum_reg, running_sum_next;
    logic                     win_next;

    logic signed [WALK_W-1:0] val_a, val_b;
    logic signed [BAND_W:0]   band_w, band_neg;
    logic                     term_a, term_b;
    logic [SAMPLE_W-1:0]      thr;
    logic signed [WALK_W:0]   walk_raw;
    logic signed [SUM_W:0]    sum_raw;
    logic [DELAY_W-1:0]       delay_max;
    logic                     dly_write;
    dfrw_dly_t                dly_now, dly_pre;

    // Configuration: always ready, values take effect at the write edge.
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb
    begin
        delay_a_next    = delay_a_reg;
        delay_b_next    = delay_b_reg;
        band_limit_next = band_limit_reg;
        burn_in_next    = burn_in_reg;
        dly_write       = 1'b0;
        if (cfg_fire)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DELAY_A:
                begin
                    delay_a_next = cfg_data[DELAY_W-1:0];
                    dly_write    = 1'b1;
                end
                REG_DELAY_B:
                begin
                    delay_b_next = cfg_data[DELAY_W-1:0];
                    dly_write    = 1'b1;
                end
                REG_BAND_LIMIT: band_limit_next = cfg_data[BAND_W-1:0];
                REG_BURN_IN:    burn_in_next    = cfg_data[BURN_W-1:0];
                default:        dly_write       = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_a_reg    <= DELAY_A_RST;
            delay_b_reg    <= DELAY_B_RST;
            band_limit_reg <= BAND_RST;
            burn_in_reg    <= BURN_RST;
        end
        else
        begin
            delay_a_reg    <= delay_a_next;
            delay_b_reg    <= delay_b_next;
            band_limit_reg <= band_limit_next;
            burn_in_reg    <= burn_in_next;
        end
    end

    // Input register and output handshake.
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            sample_reg <= s_tdata[SAMPLE_W-1:0];
        end
    end

    // Delayed history values.
    assign dly_now = '{a: delay_a_reg,  b: delay_b_reg};
    assign dly_pre = '{a: delay_a_next, b: delay_b_next};

    dfrw_hist #(
        .MAX_DELAY (MAX_DELAY)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fire),
        .wr_data (latest_next),
        .latest  (latest_reg),
        .dly_now (dly_now),
        .dly_pre (dly_pre),
        .val_a   (val_a),
        .val_b   (val_b)
    );

    // Feedback terms choose the up-step threshold.
    assign band_w   = {band_limit_reg[BAND_W-1], band_limit_reg};
    assign band_neg = -band_w;
    assign term_a   = $signed({val_a[WALK_W-1], val_a}) <= band_w;
    assign term_b   = $signed({val_b[WALK_W-1], val_b}) >= band_neg;

    always_comb
    begin
        if (term_a && !term_b)
        begin
            thr = THR_UP;
        end
        else if (!term_a && term_b)
        begin
            thr = THR_DOWN;
        end
        else
        begin
            thr = THR_HALF;
        end
    end

    // Step by one and saturate at the walk bound.
    assign walk_raw = {latest_reg[WALK_W-1], latest_reg}
                    + ((sample_reg < thr) ? 10'sd1 : -10'sd1);

    always_comb
    begin
        if (walk_raw > BOUND_P)
        begin
            latest_next = BOUND_P[WALK_W-1:0];
        end
        else if (walk_raw < BOUND_N)
        begin
            latest_next = BOUND_N[WALK_W-1:0];
        end
        else
        begin
            latest_next = walk_raw[WALK_W-1:0];
        end
    end

    // Step index saturates; before the first step it follows the delays.
    assign step_inc  = (step_index_reg == '1) ? step_index_reg : step_index_reg + 1'b1;
    assign win_next  = step_inc >= burn_in_reg;
    assign delay_max = (delay_a_next > delay_b_next) ? delay_a_next : delay_b_next;

    always_comb
    begin
        step_index_next = step_index_reg;
        if (fire)
        begin
            step_index_next = step_inc;
        end
        else if (dly_write && !stepped_reg)
        begin
            step_index_next = BURN_W'(delay_max);
        end
    end

    // Saturating running sum of values inside the window.
    assign sum_raw = {running_sum_reg[SUM_W-1], running_sum_reg}
                   + {{(SUM_W+1-WALK_W){latest_next[WALK_W-1]}}, latest_next};

    always_comb
    begin
        running_sum_next = running_sum_reg;
        if (fire && win_next)
        begin
            if (sum_raw[SUM_W] != sum_raw[SUM_W-1])
            begin
                running_sum_next = sum_raw[SUM_W] ? SUM_MIN : SUM_MAX;
            end
            else
            begin
                running_sum_next = sum_raw[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latest_reg      <= 9'sd1;
            step_index_reg  <= BURN_W'(DELAY_A_RST > DELAY_B_RST ? DELAY_A_RST : DELAY_B_RST);
            running_sum_reg <= '0;
            stepped_reg     <= 1'b0;
            win_reg         <= 1'b0;
        end
        else
        begin
            step_index_reg  <= step_index_next;
            running_sum_reg <= running_sum_next;
            if (fire)
            begin
                latest_reg  <= latest_next;
                stepped_reg <= 1'b1;
                win_reg     <= win_next;
            end
        end
    end

    // The latest value and the sum change only when a result is loaded, so
    // they serve directly as the output payload.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_OUT_W-SUM_W-WALK_W){1'b0}}, running_sum_reg, latest_reg};
    assign m_tuser  = win_reg;

`ifndef SYNTH
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $signed({latest_reg[WALK_W-1], latest_reg}) <= BOUND_P
        && $signed({latest_reg[WALK_W-1], latest_reg}) >= BOUND_N)
        else $error("walk value outside its bound");

    a_walk_step: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> ($signed({latest_reg[WALK_W-1], latest_reg})
                  - $signed({$past(latest_reg[WALK_W-1]), $past(latest_reg)}) == 10'sd1)
              || ($signed({latest_reg[WALK_W-1], latest_reg})
                  - $signed({$past(latest_reg[WALK_W-1]), $past(latest_reg)}) == -10'sd1)
              || ($signed({latest_reg[WALK_W-1], latest_reg}) == BOUND_P)
              || ($signed({latest_reg[WALK_W-1], latest_reg}) == BOUND_N))
        else $error("walk moved by other than one step");

    a_index_mono: assert property (@(posedge clk) disable iff (!rst_n)
        stepped_reg |=> step_index_reg >= $past(step_index_reg))
        else $error("step index went backward after the first step");

    a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> running_sum_reg == $past(running_sum_reg))
        else $error("running sum changed without a step");
`endif

endmodule

@@ design/dfrw_hist.sv @@
module dfrw_hist
    import dfrw_pkg::*;
#(
    parameter int MAX_DELAY = 1024
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic signed [WALK_W-1:0] wr_data,
    input  logic signed [WALK_W-1:0] latest,
    input  dfrw_dly_t                dly_now,
    input  dfrw_dly_t                dly_pre,
    output logic signed [WALK_W-1:0] val_a,
    output logic signed [WALK_W-1:0] val_b
);

    localparam int AW = $clog2(MAX_DELAY);
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_DELAY - 1);
    localparam logic [AW:0]   FULL_CNT  = (AW+1)'(MAX_DELAY);

    logic [AW-1:0] wr_slot_reg;
    logic [AW-1:0] wr_slot_next;
    logic [AW:0]   fill_reg;
    logic [AW:0]   fill_next;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic [AW-1:0] cur_a;
    logic [AW-1:0] cur_b;
    logic signed [WALK_W-1:0] rd_a_reg;
    logic signed [WALK_W-1:0] rd_b_reg;
    logic signed [WALK_W-1:0] mem [MAX_DELAY];

    // Delays past the end of the history read its oldest entry.
    function automatic logic [AW-1:0] clamp_dly(input logic [DELAY_W-1:0] d);
        logic [AW-1:0] r;
        if (32'(d) >= 32'(MAX_DELAY))
        begin
            r = LAST_SLOT;
        end
        else
        begin
            r = AW'(d);
        end
        return r;
    endfunction

    // Slot that lies c steps behind base, modulo the history depth.
    function automatic logic [AW-1:0] slot_back(input logic [AW-1:0] base,
                                                input logic [AW-1:0] c);
        logic [AW:0] s;
        s = {1'b0, base} + FULL_CNT - {1'b0, c};
        if (s >= FULL_CNT)
        begin
            s = s - FULL_CNT;
        end
        return s[AW-1:0];
    endfunction

    // Write pointer and fill count follow every step.
    always_comb
    begin
        wr_slot_next = wr_slot_reg;
        fill_next    = fill_reg;
        if (wr_en)
        begin
            wr_slot_next = (wr_slot_reg == LAST_SLOT) ? '0 : wr_slot_reg + 1'b1;
            if (fill_reg != FULL_CNT)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_slot_reg <= '0;
            fill_reg    <= '0;
        end
        else
        begin
            wr_slot_reg <= wr_slot_next;
            fill_reg    <= fill_next;
        end
    end

    // Prefetch addresses are taken against the state after this edge.
    assign addr_a = slot_back(wr_slot_next, clamp_dly(dly_pre.a));
    assign addr_b = slot_back(wr_slot_next, clamp_dly(dly_pre.b));

    // History memory, one write and two registered reads per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_slot_next] <= wr_data;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    // Entries never written read as the cleared history: the oldest slot
    // holds the start value one and anything older reads zero.
    assign cur_a = clamp_dly(dly_now.a);
    assign cur_b = clamp_dly(dly_now.b);

    always_comb
    begin
        if (cur_a == '0)
        begin
            val_a = latest;
        end
        else if ({1'b0, cur_a} < fill_reg)
        begin
            val_a = rd_a_reg;
        end
        else if ({1'b0, cur_a} == fill_reg)
        begin
            val_a = 9'sd1;
        end
        else
        begin
            val_a = '0;
        end

        if (cur_b == '0)
        begin
            val_b = latest;
        end
        else if ({1'b0, cur_b} < fill_reg)
        begin
            val_b = rd_b_reg;
        end
        else if ({1'b0, cur_b} == fill_reg)
        begin
            val_b = 9'sd1;
        end
        else
        begin
            val_b = '0;
        end
    end

`ifndef SYNTH
    // The fill count never passes the depth and moves only on a write.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_CNT)
        else $error("history fill count beyond depth");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        !wr_en |=> fill_reg == $past(fill_reg) && wr_slot_reg == $past(wr_slot_reg))
        else $error("history pointer moved without a write");
`endif

endmodule
